FILE: design/gwwlb_pkg.sv
// ----------------------------------------------------------------------------
// gwwlb_pkg
// Shared types, constants and helper functions for the greedy word-wrap
// line breaker.
// ----------------------------------------------------------------------------
package gwwlb_pkg;

  localparam int MAX_CHARS = 4096;
  localparam int IDX_W     = 12;        // character index width
  localparam int CNT_W     = 13;        // character count width (holds MAX_CHARS)
  localparam int WID_W     = 22;        // unsigned running width, 16.6
  localparam int OFS_W     = 23;        // signed pen offset / spread, 17.6
  localparam int ROW_W     = 12;
  localparam int GLY_W     = 16;        // glyph ink / advance width

  localparam logic [WID_W-1:0] WIDTH_MAX   = {WID_W{1'b1}};
  localparam logic [WID_W-1:0] LIMIT_RESET = WID_W'(6400);

  localparam int QDEPTH = 4;            // result queue entries
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_LEFT    = 2'd0,
    MODE_CENTER  = 2'd1,
    MODE_RIGHT   = 2'd2,
    MODE_JUSTIFY = 2'd3
  } align_t;

  typedef enum logic {
    REG_LINE_LIMIT = 1'b0,
    REG_ALIGN_MODE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]        first_index;
    logic [CNT_W-1:0]        char_count;
    logic signed [OFS_W-1:0] pen_offset;
    logic signed [OFS_W-1:0] spread_space;
    logic [ROW_W-1:0]        row_number;
    logic                    end_of_text;
  } result_t;

  // Saturating add of two non-negative widths.
  function automatic logic [WID_W-1:0] sat_add(input logic [WID_W-1:0] a,
                                                input logic [WID_W-1:0] b);
    logic [WID_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WID_W] ? WIDTH_MAX : s[WID_W-1:0];
  endfunction

  // a - b modulo MAX_CHARS, both operands up to MAX_CHARS.
  function automatic logic [CNT_W-1:0] span(input logic [CNT_W-1:0] a,
                                             input logic [CNT_W-1:0] b);
    logic [CNT_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[CNT_W]) begin
      d = d + (CNT_W+1)'(MAX_CHARS);
    end
    return d[CNT_W-1:0];
  endfunction

  function automatic result_t make_line(input logic [CNT_W-1:0] begin_idx,
                                        input logic [CNT_W-1:0] count,
                                        input logic [WID_W-1:0] limit,
                                        input logic [WID_W-1:0] used,
                                        input align_t           mode,
                                        input logic [ROW_W-1:0] row,
                                        input logic             last);
    result_t                 r;
    logic signed [OFS_W-1:0] left;
    left = $signed({1'b0, limit}) - $signed({1'b0, used});
    r.first_index  = begin_idx[IDX_W-1:0];
    r.char_count   = count;
    r.pen_offset   = '0;
    r.spread_space = '0;
    r.row_number   = row;
    r.end_of_text  = last;
    case (mode)
      MODE_CENTER:  r.pen_offset   = left >>> 1;  // floor of half
      MODE_RIGHT:   r.pen_offset   = left;
      MODE_JUSTIFY: r.spread_space = left;
      default:      r.pen_offset   = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/greedy_word_wrap_line_breaker.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker
// Streams classified characters and emits one descriptor per wrapped line.
// ----------------------------------------------------------------------------
// Takes one character per clock. The line state (widths, break point, line
// start) is updated in the cycle a character is accepted, and the lines it
// closes are written into a 4-entry result queue that feeds the out_ port, so
// a result waiting on out_ready never stalls the input by itself. A character
// closes at most two lines (a wrap and, on final_char, the last line); it is
// accepted only while the queue has two free entries, so the input runs at one
// character per cycle as long as the output drains one result per cycle, and
// text that wraps on most characters is paced by the single output port.
module greedy_word_wrap_line_breaker (
  input  logic                               clk,
  input  logic                               rst_n,
  // character input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_is_newline,
  input  logic                               in_is_blank,
  input  logic [gwwlb_pkg::GLY_W-1:0]        in_ink_width,
  input  logic [gwwlb_pkg::GLY_W-1:0]        in_step_advance,
  input  logic                               in_final_char,
  // line output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gwwlb_pkg::IDX_W-1:0]        out_first_index,
  output logic [gwwlb_pkg::CNT_W-1:0]        out_char_count,
  output logic signed [gwwlb_pkg::OFS_W-1:0] out_pen_offset,
  output logic signed [gwwlb_pkg::OFS_W-1:0] out_spread_space,
  output logic [gwwlb_pkg::ROW_W-1:0]        out_row_number,
  output logic                               out_end_of_text,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gwwlb_pkg::ADDR_W-1:0]       paddr,
  input  logic [gwwlb_pkg::DATA_W-1:0]       pwdata,
  output logic [gwwlb_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int IDX_W  = gwwlb_pkg::IDX_W;
  localparam int CNT_W  = gwwlb_pkg::CNT_W;
  localparam int WID_W  = gwwlb_pkg::WID_W;
  localparam int ROW_W  = gwwlb_pkg::ROW_W;
  localparam int QPTR_W = gwwlb_pkg::QPTR_W;
  localparam int QCNT_W = gwwlb_pkg::QCNT_W;

  // ---------------- configuration ----------------
  logic [WID_W-1:0]  line_limit_r;
  gwwlb_pkg::align_t align_mode_r;
  logic              cfg_wr;
  gwwlb_pkg::reg_idx_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = gwwlb_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= gwwlb_pkg::LIMIT_RESET;
      align_mode_r <= gwwlb_pkg::MODE_LEFT;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        gwwlb_pkg::REG_LINE_LIMIT: line_limit_r <= pwdata[WID_W-1:0];
        gwwlb_pkg::REG_ALIGN_MODE: align_mode_r <= gwwlb_pkg::align_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      gwwlb_pkg::REG_LINE_LIMIT: prdata = {{(32-WID_W){1'b0}}, line_limit_r};
      gwwlb_pkg::REG_ALIGN_MODE: prdata = {30'd0, align_mode_r};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- line state ----------------
  logic [IDX_W-1:0] pos_r,        pos_nxt;
  logic [CNT_W-1:0] line_begin_r, line_begin_nxt;
  logic [IDX_W-1:0] brk_pt_r,     brk_pt_nxt;
  logic [WID_W-1:0] origin_r,     origin_nxt;
  logic [WID_W-1:0] brk_wid_r,    brk_wid_nxt;
  logic [WID_W-1:0] run_wid_r,    run_wid_nxt;
  logic [WID_W-1:0] word_wid_r,   word_wid_nxt;
  logic             prior_blank_r, prior_blank_nxt;
  logic [ROW_W-1:0] row_r,        row_nxt;

  logic             in_fire;
  logic [WID_W-1:0] ink, adv, adv_eff, cur0, cur, ww_base, used;
  logic             wrap, no_bp;
  logic [CNT_W-1:0] pos_ext, wrap_count, final_count;
  gwwlb_pkg::align_t final_mode;
  gwwlb_pkg::result_t wrap_line, final_line;
  logic             push_wrap, push_final;

  assign in_fire = in_valid & in_ready;
  assign ink     = WID_W'(in_ink_width);
  assign adv     = WID_W'(in_step_advance);
  assign pos_ext = CNT_W'(pos_r);

  always_comb begin
    cur0            = gwwlb_pkg::sat_add(origin_r, ink);
    wrap            = (cur0 > line_limit_r) | in_is_newline;
    no_bp           = (brk_pt_r == '0) | in_is_newline;
    adv_eff         = in_is_newline ? '0 : adv;
    ww_base         = no_bp ? '0 : word_wid_r;
    used            = no_bp ? run_wid_r : brk_wid_r;
    wrap_count      = no_bp ? gwwlb_pkg::span(pos_ext, line_begin_r)
                            : gwwlb_pkg::span(CNT_W'(brk_pt_r), line_begin_r) + 1'b1;

    line_begin_nxt  = line_begin_r;
    brk_pt_nxt      = brk_pt_r;
    brk_wid_nxt     = brk_wid_r;
    word_wid_nxt    = word_wid_r;
    origin_nxt      = gwwlb_pkg::sat_add(origin_r, adv);
    row_nxt         = row_r;
    cur             = cur0;

    if (wrap) begin
      line_begin_nxt = no_bp ? (in_is_newline ? pos_ext + 1'b1 : pos_ext)
                             : CNT_W'(brk_pt_r) + 1'b1;
      brk_wid_nxt    = used;
      word_wid_nxt   = gwwlb_pkg::sat_add(ww_base, adv_eff);
      origin_nxt     = word_wid_nxt;
      // carried width counts the advance twice
      cur            = gwwlb_pkg::sat_add(word_wid_nxt, adv_eff);
      brk_pt_nxt     = '0;
      row_nxt        = row_r + 1'b1;
    end else if (in_is_blank) begin
      word_wid_nxt = '0;
      brk_pt_nxt   = pos_r;
      if ((pos_r == '0) || !prior_blank_r) begin
        brk_wid_nxt = cur0;
      end
    end else begin
      word_wid_nxt = gwwlb_pkg::sat_add(word_wid_r, adv);
    end

    run_wid_nxt     = cur;
    prior_blank_nxt = in_is_newline | in_is_blank;
    pos_nxt         = pos_r + 1'b1;

    final_mode  = (align_mode_r == gwwlb_pkg::MODE_JUSTIFY) ? gwwlb_pkg::MODE_LEFT
                                                             : align_mode_r;
    final_count = gwwlb_pkg::span(pos_ext + 1'b1, line_begin_nxt);
    wrap_line   = gwwlb_pkg::make_line(line_begin_r, wrap_count, line_limit_r, used,
                                       align_mode_r, row_r, 1'b0);
    final_line  = gwwlb_pkg::make_line(line_begin_nxt, final_count, line_limit_r, cur,
                                       final_mode, row_nxt, 1'b1);
    push_wrap   = in_fire & wrap;
    push_final  = in_fire & in_final_char;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_final_char)) begin
      pos_r         <= '0;
      line_begin_r  <= '0;
      brk_pt_r      <= '0;
      origin_r      <= '0;
      brk_wid_r     <= '0;
      run_wid_r     <= '0;
      word_wid_r    <= '0;
      prior_blank_r <= 1'b0;
      row_r         <= '0;
    end else if (in_fire) begin
      pos_r         <= pos_nxt;
      line_begin_r  <= line_begin_nxt;
      brk_pt_r      <= brk_pt_nxt;
      origin_r      <= origin_nxt;
      brk_wid_r     <= brk_wid_nxt;
      run_wid_r     <= run_wid_nxt;
      word_wid_r    <= word_wid_nxt;
      prior_blank_r <= prior_blank_nxt;
      row_r         <= row_nxt;
    end
  end

  // ---------------- result queue ----------------
  gwwlb_pkg::result_t q_mem [gwwlb_pkg::QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  q_cnt_r;
  logic               pop;
  logic [QPTR_W-1:0]  wr_ptr_p1;
  logic [1:0]         n_push;
  gwwlb_pkg::result_t head;

  assign in_ready  = (q_cnt_r <= QCNT_W'(gwwlb_pkg::QDEPTH - 2));
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign n_push    = {1'b0, push_wrap} + {1'b0, push_final};

  always_ff @(posedge clk) begin
    if (push_wrap) begin
      q_mem[wr_ptr_r] <= wrap_line;
    end
    if (push_final) begin
      q_mem[push_wrap ? wr_ptr_p1 : wr_ptr_r] <= final_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  assign head             = q_mem[rd_ptr_r];
  assign out_first_index  = head.first_index;
  assign out_char_count   = head.char_count;
  assign out_pen_offset   = head.pen_offset;
  assign out_spread_space = head.spread_space;
  assign out_row_number   = head.row_number;
  assign out_end_of_text  = head.end_of_text;

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: greedy word-wrap line breaker testbench
// Streams classified characters into the line breaker and checks each line
// descriptor it emits against an in-bench line predictor. Covers directed
// corner cases, random text over a sweep of line limits and alignments,
// output back-pressure, width saturation and one long string of short rows.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W     = gwwlb_pkg::IDX_W;
  localparam int CNT_W     = gwwlb_pkg::CNT_W;
  localparam int OFS_W     = gwwlb_pkg::OFS_W;
  localparam int ROW_W     = gwwlb_pkg::ROW_W;
  localparam int GLY_W     = gwwlb_pkg::GLY_W;
  localparam int ADDR_W    = gwwlb_pkg::ADDR_W;
  localparam int DATA_W    = gwwlb_pkg::DATA_W;
  localparam int MAX_CHARS = gwwlb_pkg::MAX_CHARS;

  typedef struct packed {
    logic             nl;
    logic             blank;
    logic [GLY_W-1:0] ink;
    logic [GLY_W-1:0] adv;
    logic             fin;
  } glyph_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_is_newline = 1'b0;
  logic             in_is_blank = 1'b0;
  logic [GLY_W-1:0] in_ink_width = '0;
  logic [GLY_W-1:0] in_step_advance = '0;
  logic             in_final_char = 1'b0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        out_first_index;
  logic [CNT_W-1:0]        out_char_count;
  logic signed [OFS_W-1:0] out_pen_offset;
  logic signed [OFS_W-1:0] out_spread_space;
  logic [ROW_W-1:0]        out_row_number;
  logic                    out_end_of_text;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  greedy_word_wrap_line_breaker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_is_newline    (in_is_newline),
    .in_is_blank      (in_is_blank),
    .in_ink_width     (in_ink_width),
    .in_step_advance  (in_step_advance),
    .in_final_char    (in_final_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_first_index  (out_first_index),
    .out_char_count   (out_char_count),
    .out_pen_offset   (out_pen_offset),
    .out_spread_space (out_spread_space),
    .out_row_number   (out_row_number),
    .out_end_of_text  (out_end_of_text),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  // configuration copy
  int                limit_reg = int'(gwwlb_pkg::LIMIT_RESET);
  gwwlb_pkg::align_t align_reg = gwwlb_pkg::MODE_LEFT;

  // line predictor state
  logic [IDX_W-1:0] char_idx = '0;
  logic [CNT_W-1:0] line_start = '0;
  logic [IDX_W-1:0] brk_idx = '0;     // zero doubles as "no break point"
  int               pen_x = 0;
  int               brk_width = 0;
  int               ink_end = 0;
  int               word_run = 0;
  bit               last_was_space = 1'b0;
  logic [ROW_W-1:0] row_cnt = '0;

  gwwlb_pkg::result_t pending_lines[$];
  int      mismatches = 0;
  int      idle_pct = 20;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  function automatic glyph_t glyph(input logic nl, input logic blank,
                                   input logic [GLY_W-1:0] ink,
                                   input logic [GLY_W-1:0] adv, input logic fin);
    glyph_t g;
    g.nl = nl;
    g.blank = blank;
    g.ink = ink;
    g.adv = adv;
    g.fin = fin;
    return g;
  endfunction

  function automatic int add_sat(input int a, input int b);
    int s;
    s = a + b;
    if (s > int'(gwwlb_pkg::WIDTH_MAX)) s = int'(gwwlb_pkg::WIDTH_MAX);
    if (s < 0) s = 0;
    return s;
  endfunction

  // a - b modulo MAX_CHARS, b may equal MAX_CHARS
  function automatic logic [CNT_W-1:0] char_gap(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    if (a >= b) return a - b;
    return a + CNT_W'(MAX_CHARS) - b;
  endfunction

  function automatic gwwlb_pkg::result_t line_desc(input logic [CNT_W-1:0] count,
                                                   input int left,
                                                   input gwwlb_pkg::align_t mode,
                                                   input logic last);
    gwwlb_pkg::result_t r;
    r.first_index  = line_start[IDX_W-1:0];
    r.char_count   = count;
    r.pen_offset   = '0;
    r.spread_space = '0;
    r.row_number   = row_cnt;
    r.end_of_text  = last;
    case (mode)
      gwwlb_pkg::MODE_CENTER:  r.pen_offset = OFS_W'(left >>> 1);
      gwwlb_pkg::MODE_RIGHT:   r.pen_offset = OFS_W'(left);
      gwwlb_pkg::MODE_JUSTIFY: r.spread_space = OFS_W'(left);
      default:                 r.pen_offset = '0;
    endcase
    return r;
  endfunction

  function automatic void clear_text();
    char_idx = '0;
    line_start = '0;
    brk_idx = '0;
    pen_x = 0;
    brk_width = 0;
    ink_end = 0;
    word_run = 0;
    last_was_space = 1'b0;
    row_cnt = '0;
  endfunction

  // Advance the line state by one accepted character, queue the lines it closes.
  function automatic void wrap_char(input glyph_t g);
    int                ink, adv, cur, prev, bw;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count, start;
    gwwlb_pkg::align_t last_mode;
    ink = g.ink;
    adv = g.adv;
    idx = char_idx;
    prev = ink_end;
    cur = add_sat(pen_x, ink);
    pen_x = add_sat(pen_x, adv);
    if (cur > limit_reg || g.nl) begin
      if (brk_idx == '0 || g.nl) begin
        count = char_gap({1'b0, idx}, line_start);
        start = g.nl ? {1'b0, idx} + CNT_W'(1) : {1'b0, idx};
        bw = prev;
        word_run = 0;
        if (g.nl) adv = 0;
      end else begin
        count = char_gap({1'b0, brk_idx}, line_start) + CNT_W'(1);
        start = {1'b0, brk_idx} + CNT_W'(1);
        bw = brk_width;
      end
      brk_width = bw;
      pending_lines.push_back(line_desc(count, limit_reg - bw, align_reg, 1'b0));
      row_cnt = row_cnt + ROW_W'(1);
      line_start = start;
      pen_x = add_sat(word_run, adv);
      word_run = add_sat(word_run, adv);
      cur = add_sat(word_run, adv);
      brk_idx = '0;
    end else if (g.blank) begin
      word_run = 0;
      brk_idx = idx;
      if (idx == '0 || !last_was_space) brk_width = cur;
    end else begin
      word_run = add_sat(word_run, adv);
    end
    ink_end = cur;
    last_was_space = g.nl || g.blank;
    if (g.fin) begin
      // justify never applies to the closing line
      last_mode = (align_reg == gwwlb_pkg::MODE_JUSTIFY) ? gwwlb_pkg::MODE_LEFT
                                                          : align_reg;
      pending_lines.push_back(line_desc(char_gap({1'b0, idx} + CNT_W'(1), line_start),
                                        limit_reg - cur, last_mode, 1'b1));
      clear_text();
    end else begin
      char_idx = idx + IDX_W'(1);
    end
  endfunction

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic string show(input gwwlb_pkg::result_t r);
    return $sformatf("idx=%0d cnt=%0d pen=%0d spread=%0d row=%0d eot=%0b",
                     r.first_index, r.char_count, r.pen_offset, r.spread_space,
                     r.row_number, r.end_of_text);
  endfunction

  // Prediction on input transactions, checking on output transactions.
  always @(posedge clk) begin
    gwwlb_pkg::result_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready)
        wrap_char(glyph(in_is_newline, in_is_blank, in_ink_width, in_step_advance,
                        in_final_char));
      if (out_valid && out_ready) begin
        got.first_index  = out_first_index;
        got.char_count   = out_char_count;
        got.pen_offset   = out_pen_offset;
        got.spread_space = out_spread_space;
        got.row_number   = out_row_number;
        got.end_of_text  = out_end_of_text;
        if (pending_lines.size() == 0) begin
          flag($sformatf("unexpected line: %s", show(got)));
        end else begin
          want = pending_lines.pop_front();
          if (got !== want)
            flag($sformatf("line mismatch: exp %s / got %s", show(want), show(got)));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_char(input glyph_t g);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_is_newline <= g.nl;
    in_is_blank <= g.blank;
    in_ink_width <= g.ink;
    in_step_advance <= g.adv;
    in_final_char <= g.fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted line has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input gwwlb_pkg::reg_idx_t idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] stored;
    stored = (idx == gwwlb_pkg::REG_LINE_LIMIT) ? (val & DATA_W'(gwwlb_pkg::WIDTH_MAX))
                                                : (val & DATA_W'(3));
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == gwwlb_pkg::REG_LINE_LIMIT) limit_reg = int'(stored);
    else align_reg = gwwlb_pkg::align_t'(stored[1:0]);
    // read back
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored)
      flag($sformatf("register %s read back %0h, exp %0h", idx.name(), prdata, stored));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [GLY_W-1:0] pick_w(input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    return GLY_W'($urandom_range(hi));
  endfunction

  // One string of random characters, the last one flagged final.
  task automatic send_text(input int len, input int hi, input int pct_blank,
                           input int pct_nl);
    int   r;
    logic nl, blank;
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      nl = (r < pct_nl);
      blank = (r + 1 >= pct_nl) && (r < pct_nl + pct_blank);  // overlap: both set
      send_char(glyph(nl, blank, pick_w(hi), pick_w(hi), k == len - 1));
    end
  endtask

  task automatic test_directed();
    // blank at index 0 gives no usable break point
    send_char(glyph(1'b0, 1'b1, 16'd100, 16'd200, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd7000, 16'd300, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd50, 16'd60, 1'b1));
    // leading newline, newline+blank, final on a newline
    send_char(glyph(1'b1, 1'b0, 16'd500, 16'd500, 1'b0));
    send_char(glyph(1'b1, 1'b1, 16'd40, 16'd40, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd64, 16'd64, 1'b0));
    send_char(glyph(1'b1, 1'b0, 16'd0, 16'd0, 1'b1));
    // ordinary wrap at the last blank
    send_char(glyph(1'b0, 1'b0, 16'd1000, 16'd1500, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd1000, 16'd1500, 1'b0));
    send_char(glyph(1'b0, 1'b1, 16'd1000, 16'd1500, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd1000, 16'd1500, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd1000, 16'd1500, 1'b1));
    // run of blanks keeps the width of the first one
    send_char(glyph(1'b0, 1'b0, 16'd2000, 16'd2000, 1'b0));
    send_char(glyph(1'b0, 1'b1, 16'd2000, 16'd2000, 1'b0));
    send_char(glyph(1'b0, 1'b1, 16'd2000, 16'd2000, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd2000, 16'd2000, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'd2000, 16'd2000, 1'b1));
    // field extremes
    send_char(glyph(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0));
    send_char(glyph(1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_char(glyph(1'b0, 1'b1, 16'hFFFF, 16'h0000, 1'b1));
    // one-character string
    send_char(glyph(1'b0, 1'b0, 16'd10, 16'd10, 1'b1));
    settle();
  endtask

  // Zero limit wraps nearly every character; the receiver stops long enough
  // for the result queue to fill and back up the input.
  task automatic test_output_stall();
    reg_write(gwwlb_pkg::REG_LINE_LIMIT, '0);
    reg_write(gwwlb_pkg::REG_ALIGN_MODE, DATA_W'(gwwlb_pkg::MODE_RIGHT));
    hold_req = 1'b1;
    send_text(60, 500, 10, 10);
    settle();
  endtask

  task automatic test_random_text();
    int lim, hi, sent, len;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0:       lim = 0;
        1:       lim = 1;
        2:       lim = 6400;
        3:       lim = int'(gwwlb_pkg::WIDTH_MAX);
        4:       lim = $urandom_range(20000, 64);
        default: lim = $urandom_range(int'(gwwlb_pkg::WIDTH_MAX));
      endcase
      idle_pct = (ph == 5 || ph == 6) ? 0 : 20;
      reg_write(gwwlb_pkg::REG_LINE_LIMIT, DATA_W'(lim));
      reg_write(gwwlb_pkg::REG_ALIGN_MODE, DATA_W'(ph % 4));
      hi = lim / 3;
      if (hi < 16) hi = 16;
      if (hi > 65535) hi = 65535;
      sent = 0;
      while (sent < 72) begin
        len = $urandom_range(30, 1);
        send_text(len, hi, 12, 4);
        sent += len;
      end
      settle();
    end
    idle_pct = 20;
  endtask

  task automatic test_width_saturation();
    reg_write(gwwlb_pkg::REG_LINE_LIMIT, DATA_W'(gwwlb_pkg::WIDTH_MAX));
    reg_write(gwwlb_pkg::REG_ALIGN_MODE, DATA_W'(gwwlb_pkg::MODE_RIGHT));
    for (int k = 0; k < 70; k++)
      send_char(glyph(1'b0, k % 9 == 4, 16'hFFFF, 16'hFFFF, k == 69));
    settle();
    reg_write(gwwlb_pkg::REG_LINE_LIMIT, DATA_W'(4194000));
    reg_write(gwwlb_pkg::REG_ALIGN_MODE, DATA_W'(gwwlb_pkg::MODE_CENTER));
    for (int k = 0; k < 140; k++)
      send_char(glyph(1'b0, k % 11 == 6, 16'hFFFF, 16'hFFF0, k == 139));
    settle();
  endtask

  // One long string with a tiny limit: many short rows, all but the closing one justified.
  task automatic test_long_text();
    reg_write(gwwlb_pkg::REG_LINE_LIMIT, DATA_W'(64));
    reg_write(gwwlb_pkg::REG_ALIGN_MODE, DATA_W'(gwwlb_pkg::MODE_JUSTIFY));
    send_text(650, 200, 10, 10);
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_stall();
    test_random_text();
    test_width_saturation();
    test_long_text();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_lines.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
design/gwwlb_pkg.sv
design/greedy_word_wrap_line_breaker.sv
sim/tb.sv
